// ===== sv/res_pkg.sv =====
// Shared types and constants for the ring entry store with offset lookup.
// Used by res_ctrl and the top level; depends on nothing else.
`default_nettype none

package res_pkg;

    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFS_W   = 20;
    localparam int SLOT_W   = 4;

    // operation codes carried in tuser
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_FIND,
        S_DONE
    } t_state;

    // result word, lowest bit first: accepted, found, evicted, slot, handle, byte
    typedef struct packed {
        logic [SIZE_W-1:0]   byte_in_entry;
        logic [HANDLE_W-1:0] handle_out;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic                found;
        logic                accepted;
    } t_res;

endpackage

`default_nettype wire

// ===== sv/ring_entry_store_with_offset_lookup.sv =====
// Ring of DEPTH entries (handle, byte size) that overwrites the oldest entry
// when full, with lookup of a character offset across the entries oldest first.
// An add goes from accept to result through a memory read of the slot being
// overwritten, a write-back and the result hand-off; a rejected zero-size add
// goes straight to the result. A find walks the entry memory one slot a cycle
// from the oldest entry up to the one that holds the offset, or over all DEPTH
// entries when none does. One item is in work at a time; a finished result sits
// in the output register so the next word is taken while it waits. Entries
// come up empty at reset through per-entry valid bits, with no clearing pass.
// Depends on res_pkg, res_ctrl and res_mem.
`default_nettype none

module ring_entry_store_with_offset_lookup
    import res_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [31:0] new_handle, [47:32] new_size, [67:48] lookup_pos, [71:68] zero
    input  wire logic [71:0] i_s_tdata,
    // [0] op
    input  wire logic [0:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] accepted, [1] found, [2] evicted, [6:3] slot, [38:7] handle_out,
    // [54:39] byte_in_entry, [55] zero
    output logic      [55:0] o_m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                res_valid;
    t_res                res;
    logic                res_ready;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [HANDLE_W-1:0] wr_handle;
    logic [SIZE_W-1:0]   wr_size;
    logic [AW-1:0]       raddr;
    logic [HANDLE_W-1:0] rd_handle;
    logic [SIZE_W-1:0]   rd_size;
    logic                r_out_valid;
    t_res                r_out;

    res_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser[0]),
        .i_handle    (i_s_tdata[31:0]),
        .i_size      (i_s_tdata[47:32]),
        .i_offs      (i_s_tdata[67:48]),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wr_handle (wr_handle),
        .o_wr_size   (wr_size),
        .o_raddr     (raddr),
        .i_rd_handle (rd_handle),
        .i_rd_size   (rd_size)
    );

    res_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .HW    (HANDLE_W),
        .SW    (SIZE_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (we),
        .i_waddr     (waddr),
        .i_wr_handle (wr_handle),
        .i_wr_size   (wr_size),
        .i_raddr     (raddr),
        .o_rd_handle (rd_handle),
        .o_rd_size   (rd_size)
    );

    // output word register: load when empty or being drained
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

endmodule

`default_nettype wire

// ===== sv/res_mem.sv =====
// Entry memory: handle and size arrays, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
`default_nettype none

module res_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int HW    = 32,
    parameter int SW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [HW-1:0] i_wr_handle,
    input  wire logic [SW-1:0] i_wr_size,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [HW-1:0] o_rd_handle,
    output logic      [SW-1:0] o_rd_size
);

    logic [HW-1:0]    r_handle_mem [DEPTH];
    logic [SW-1:0]    r_size_mem   [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [HW-1:0]    r_rd_handle;
    logic [SW-1:0]    r_rd_size;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_handle_mem[i_waddr] <= i_wr_handle;
            r_size_mem[i_waddr]   <= i_wr_size;
        end
        r_rd_handle <= r_handle_mem[i_raddr];
        r_rd_size   <= r_size_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_raddr];
        end
    end

    // never-written entries read as zero
    assign o_rd_handle = r_rd_vld ? r_rd_handle : '0;
    assign o_rd_size   = r_rd_vld ? r_rd_size   : '0;

endmodule

`default_nettype wire

// ===== sv/res_ctrl.sv =====
// Sequencer for adds and finds: ring indexes, memory access and result forming.
// Depends on res_pkg; drives the ports of res_mem.
`default_nettype none

module res_ctrl
    import res_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_op,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [SIZE_W-1:0]   i_size,
    input  wire logic [OFFS_W-1:0]   i_offs,
    output logic                     o_res_valid,
    output t_res                     o_res,
    input  wire logic                i_res_ready,
    output logic                     o_we,
    output logic      [AW-1:0]       o_waddr,
    output logic      [HANDLE_W-1:0] o_wr_handle,
    output logic      [SIZE_W-1:0]   o_wr_size,
    output logic      [AW-1:0]       o_raddr,
    input  wire logic [HANDLE_W-1:0] i_rd_handle,
    input  wire logic [SIZE_W-1:0]   i_rd_size
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] x);
        return (x == LAST) ? '0 : x + AW'(1);
    endfunction

    t_state               r_state, n_state;
    logic [HANDLE_W-1:0]  r_handle, n_handle;
    logic [SIZE_W-1:0]    r_size, n_size;
    logic [OFFS_W-1:0]    r_offs, n_offs;
    logic [AW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]        r_wr_idx, n_wr_idx;
    logic [AW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_full, n_full;
    t_res                 r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_full   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_full   <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_size   <= n_size;
        r_offs   <= n_offs;
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_handle = r_handle;
        n_size   = r_size;
        n_offs   = r_offs;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_full   = r_full;
        n_res    = r_res;
        o_we     = 1'b0;
        o_raddr  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_raddr = (i_op == OP_ADD) ? r_wr_idx : r_rd_idx;
                if (i_valid) begin
                    n_handle = i_handle;
                    n_size   = i_size;
                    n_offs   = i_offs;
                    n_pos    = r_rd_idx;
                    n_cnt    = '0;
                    if (i_op == OP_FIND) begin
                        n_state = S_FIND;
                    end else if (i_size == '0) begin
                        // rejected add: all-zero result, state untouched
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                // old handle at the write slot has arrived; overwrite it now
                o_we             = 1'b1;
                n_res            = '0;
                n_res.accepted   = 1'b1;
                n_res.evicted    = r_full;
                n_res.handle_out = r_full ? i_rd_handle : '0;
                n_wr_idx         = nxt(r_wr_idx);
                n_rd_idx         = r_full ? nxt(r_rd_idx) : r_rd_idx;
                if (n_wr_idx == n_rd_idx) begin
                    n_full = 1'b1;
                end
                n_state = S_DONE;
            end
            S_FIND: begin
                // data for r_pos is here; fetch the following slot meanwhile
                o_raddr = nxt(r_pos);
                n_pos   = nxt(r_pos);
                n_cnt   = r_cnt + AW'(1);
                if (r_offs < OFFS_W'(i_rd_size)) begin
                    n_res               = '0;
                    n_res.accepted      = 1'b1;
                    n_res.found         = 1'b1;
                    n_res.slot          = SLOT_W'(r_pos);
                    n_res.handle_out    = i_rd_handle;
                    n_res.byte_in_entry = r_offs[SIZE_W-1:0];
                    n_state             = S_DONE;
                end else begin
                    n_offs = r_offs - OFFS_W'(i_rd_size);
                    if (r_cnt == LAST) begin
                        n_res          = '0;
                        n_res.accepted = 1'b1;
                        n_state        = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_waddr     = r_wr_idx;
    assign o_wr_handle = r_handle;
    assign o_wr_size   = r_size;

`ifndef SYNTHESIS
    a_full_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("ring full flag dropped");
    a_full_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_rd_idx == r_wr_idx))
        else $error("read and write index differ on a full ring");
    a_empty_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_full |-> (r_rd_idx == '0))
        else $error("read index moved before the ring filled");
    a_found_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.found) |-> (o_res.accepted && !o_res.evicted))
        else $error("find result marked evicted or not accepted");
`endif

endmodule

`default_nettype wire
